// ===== sv/swhsr_pkg.sv =====
// Shared constants, types and handshake structs for the single-wire humidity sensor reader.
package swhsr_pkg;

  localparam int HIST_DEPTH = 16;
  localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int CNT_W      = $clog2(HIST_DEPTH + 1);
  localparam int SUM_W      = $clog2(255 * HIST_DEPTH + 1);
  localparam int DIV_W      = $clog2(25500 * HIST_DEPTH + 1);
  localparam int DCNT_W     = $clog2(DIV_W + 1);
  localparam int HQ_W       = 15;
  localparam int RECIP_W    = 16;
  localparam int RECIP_SH   = 22;
  localparam int PROD_W     = HQ_W + RECIP_W;

  localparam logic [RECIP_W-1:0] RECIP_100 = 16'd41944;
  localparam logic [5:0]         FRAME_LAST = 6'd39;

  localparam logic [1:0] DRV_REL  = 2'd0;
  localparam logic [1:0] DRV_LOW  = 2'd1;
  localparam logic [1:0] DRV_HIGH = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_CSUM    = 2'd2;

  localparam logic [1:0] CFG_START_LOW   = 2'd0;
  localparam logic [1:0] CFG_RELEASE_HI  = 2'd1;
  localparam logic [1:0] CFG_THRESHOLD   = 2'd2;
  localparam logic [1:0] CFG_TIMEOUT     = 2'd3;

  typedef enum logic [6:0] {
    PH_IDLE     = 7'b0000001,
    PH_LOW      = 7'b0000010,
    PH_HIGH     = 7'b0000100,
    PH_ACK_LOW  = 7'b0001000,
    PH_ACK_HIGH = 7'b0010000,
    PH_BIT_LOW  = 7'b0100000,
    PH_BIT_HIGH = 7'b1000000
  } phase_t;

  typedef enum logic [3:0] {
    SQ_RUN = 4'b0001,
    SQ_DIV = 4'b0010,
    SQ_MUL = 4'b0100,
    SQ_FIN = 4'b1000
  } seq_t;

  typedef struct packed {
    logic       tick_clr;
    logic       tick_inc;
    logic       frame_clr;
    logic       bit_shift;
    logic       fin;
    logic [1:0] fin_status;
    logic       commit;
    logic       div_step;
    logic       mul;
    logic       load_out;
    logic       load_avg;
    logic [1:0] drive;
    logic       busy;
    logic       done;
  } cmd_t;

  typedef struct packed {
    logic ge_low;
    logic ge_high;
    logic ge_tmo;
    logic len_gt;
    logic last_bit;
    logic csum_ok;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/swhsr_ctrl.sv =====
// Controller: sensor protocol phases and the per-transaction sequencer.
module swhsr_ctrl import swhsr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_start_req,
  input  logic in_line_level,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  phase_t phase_r, phase_nxt;
  seq_t   seq_r, seq_nxt;
  logic   acc;

  assign in_stall = !((seq_r == SQ_RUN) && sts.out_free);
  assign acc      = in_valid && !in_stall;

  always_comb begin
    cmd       = '0;
    phase_nxt = phase_r;
    seq_nxt   = seq_r;
    unique case (seq_r)
      SQ_RUN: begin
        if (acc) begin
          cmd.load_out = 1'b1;
          cmd.busy     = (phase_r != PH_IDLE);
          unique case (phase_r)
            PH_IDLE: begin
              if (in_start_req) begin
                cmd.tick_clr  = 1'b1;
                cmd.frame_clr = 1'b1;
                phase_nxt     = PH_LOW;
              end
            end
            PH_LOW: begin
              cmd.drive    = DRV_LOW;
              cmd.tick_inc = 1'b1;
              if (sts.ge_low) begin
                cmd.tick_clr = 1'b1;
                phase_nxt    = PH_HIGH;
              end
            end
            PH_HIGH: begin
              cmd.drive    = DRV_HIGH;
              cmd.tick_inc = 1'b1;
              if (sts.ge_high) begin
                cmd.tick_clr = 1'b1;
                phase_nxt    = PH_ACK_LOW;
              end
            end
            PH_ACK_LOW, PH_ACK_HIGH, PH_BIT_LOW, PH_BIT_HIGH: begin
              // low-level phases wait for a rise, high-level ones for a fall
              if (in_line_level == ((phase_r == PH_ACK_LOW) || (phase_r == PH_BIT_LOW))) begin
                cmd.tick_clr = 1'b1;
                priority case (1'b1)
                  phase_r == PH_ACK_LOW:  phase_nxt = PH_ACK_HIGH;
                  phase_r == PH_ACK_HIGH: phase_nxt = PH_BIT_LOW;
                  phase_r == PH_BIT_LOW:  phase_nxt = PH_BIT_HIGH;
                  default: begin
                    cmd.bit_shift = 1'b1;
                    if (!sts.last_bit) begin
                      phase_nxt = PH_BIT_LOW;
                    end else if (sts.csum_ok) begin
                      // hold the result back until the new averages are ready
                      cmd.commit     = 1'b1;
                      cmd.load_out   = 1'b0;
                      cmd.fin        = 1'b1;
                      cmd.fin_status = ST_OK;
                      phase_nxt      = PH_IDLE;
                      seq_nxt        = SQ_DIV;
                    end else begin
                      cmd.fin        = 1'b1;
                      cmd.fin_status = ST_CSUM;
                      cmd.done       = 1'b1;
                      phase_nxt      = PH_IDLE;
                    end
                  end
                endcase
              end else if (sts.ge_tmo) begin
                cmd.fin        = 1'b1;
                cmd.fin_status = ST_TIMEOUT;
                cmd.tick_clr   = 1'b1;
                cmd.done       = 1'b1;
                phase_nxt      = PH_IDLE;
              end else begin
                cmd.tick_inc = 1'b1;
              end
            end
            default: begin
              cmd.fin        = 1'b1;
              cmd.fin_status = ST_TIMEOUT;
              cmd.tick_clr   = 1'b1;
              cmd.done       = 1'b1;
              phase_nxt      = PH_IDLE;
            end
          endcase
        end
      end
      SQ_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) seq_nxt = SQ_MUL;
      end
      SQ_MUL: begin
        cmd.mul = 1'b1;
        seq_nxt = SQ_FIN;
      end
      SQ_FIN: begin
        cmd.drive    = DRV_REL;
        cmd.busy     = 1'b1;
        cmd.done     = 1'b1;
        cmd.load_avg = 1'b1;
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          seq_nxt      = SQ_RUN;
        end
      end
      default: seq_nxt = SQ_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      seq_r   <= SQ_RUN;
    end else begin
      phase_r <= phase_nxt;
      seq_r   <= seq_nxt;
    end
  end

  a_seq_idle: assert property (@(posedge clk) disable iff (!rst_n)
    seq_r != SQ_RUN |-> phase_r == PH_IDLE) else $error("sequencer busy outside idle phase");
  a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    seq_r != SQ_RUN |-> in_stall) else $error("input taken while averaging");
  a_commit_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> seq_r == SQ_DIV) else $error("commit did not start divider");

endmodule

// ===== sv/swhsr_dp.sv =====
// Datapath: tick counter, frame shifter, histories, sums, divider and result register.
module swhsr_dp import swhsr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data,
  input  logic        out_stall,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic        out_valid,
  output logic [1:0]  out_line_drive,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic [1:0]  out_status,
  output logic [7:0]  out_humidity_last,
  output logic [7:0]  out_temperature_last,
  output logic        out_last_valid,
  output logic        out_average_valid,
  output logic [7:0]  out_humidity_avg_whole,
  output logic [6:0]  out_humidity_avg_hundredths,
  output logic [7:0]  out_temperature_avg_whole,
  output logic [6:0]  out_temperature_avg_hundredths
);

  logic [19:0] start_low_r;
  logic [15:0] rel_high_r, thr_r, tmo_r;
  logic [19:0] tick_r;
  logic [20:0] tick_p1;
  logic [5:0]  bits_r;
  logic [39:0] frame_r, frame_sh;
  logic [1:0]  status_r;
  logic [7:0]  hum_r, tmp_r, new_h, new_t, old_h, old_t;
  logic        lvalid_r, full;
  logic [7:0]  hum_mem [HIST_DEPTH];
  logic [7:0]  tmp_mem [HIST_DEPTH];
  logic [HIST_AW-1:0] pos_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [SUM_W-1:0]   hsum_r, tsum_r, hsum_nxt, tsum_nxt;
  logic [DIV_W-1:0]   dh_r, dt_r;
  logic [CNT_W:0]     rh_r, rt_r, rh_sh, rt_sh, dvs;
  logic               geh, get;
  logic [DCNT_W-1:0]  dcnt_r;
  logic [PROD_W-1:0]  ph_r, pt_r;
  logic [7:0]  ahw_r, atw_r, ahw_new, atw_new;
  logic [6:0]  ahh_r, ath_r, ahh_new, ath_new;
  logic        out_valid_r;

  assign tick_p1  = {1'b0, tick_r} + 21'd1;
  assign frame_sh = {frame_r[38:0], sts.len_gt};
  assign new_h    = frame_sh[39:32];
  assign new_t    = frame_sh[23:16];
  assign full     = (cnt_r == CNT_W'(HIST_DEPTH));
  assign old_h    = hum_mem[pos_r];
  assign old_t    = tmp_mem[pos_r];
  assign hsum_nxt = hsum_r - (full ? SUM_W'(old_h) : '0) + SUM_W'(new_h);
  assign tsum_nxt = tsum_r - (full ? SUM_W'(old_t) : '0) + SUM_W'(new_t);

  always_comb begin
    sts.ge_low   = tick_p1 >= {1'b0, start_low_r};
    sts.ge_high  = tick_p1 >= 21'(rel_high_r);
    sts.ge_tmo   = tick_r >= 20'(tmo_r);
    sts.len_gt   = tick_p1 > 21'(thr_r);
    sts.last_bit = bits_r >= FRAME_LAST;
    sts.csum_ok  = 8'(frame_sh[39:32] + frame_sh[23:16]) == frame_sh[7:0];
    sts.div_last = (dcnt_r == '0);
    sts.out_free = !out_valid_r || !out_stall;
  end

  // one restoring step per cycle for both averages
  assign dvs   = {1'b0, cnt_r};
  assign rh_sh = {rh_r[CNT_W-1:0], dh_r[DIV_W-1]};
  assign rt_sh = {rt_r[CNT_W-1:0], dt_r[DIV_W-1]};
  assign geh   = rh_sh >= dvs;
  assign get   = rt_sh >= dvs;

  assign ahw_new = ph_r[RECIP_SH +: 8];
  assign atw_new = pt_r[RECIP_SH +: 8];
  assign ahh_new = 7'(dh_r[HQ_W-1:0] - HQ_W'(ahw_new) * HQ_W'(100));
  assign ath_new = 7'(dt_r[HQ_W-1:0] - HQ_W'(atw_new) * HQ_W'(100));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_low_r <= 20'd18000;
      rel_high_r  <= 16'd40;
      thr_r       <= 16'd40;
      tmo_r       <= 16'd10000;
      tick_r      <= '0;
      bits_r      <= '0;
      frame_r     <= '0;
      status_r    <= ST_OK;
      hum_r       <= '0;
      tmp_r       <= '0;
      lvalid_r    <= 1'b0;
      pos_r       <= '0;
      cnt_r       <= '0;
      hsum_r      <= '0;
      tsum_r      <= '0;
      ahw_r       <= '0;
      ahh_r       <= '0;
      atw_r       <= '0;
      ath_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_START_LOW:  start_low_r <= cfg_data;
          CFG_RELEASE_HI: rel_high_r  <= cfg_data[15:0];
          CFG_THRESHOLD:  thr_r       <= cfg_data[15:0];
          CFG_TIMEOUT:    tmo_r       <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (cmd.tick_clr) tick_r <= '0;
      else if (cmd.tick_inc) tick_r <= tick_p1[19:0];
      if (cmd.frame_clr) begin
        bits_r  <= '0;
        frame_r <= '0;
      end else if (cmd.bit_shift) begin
        bits_r  <= bits_r + 6'd1;
        frame_r <= frame_sh;
      end
      if (cmd.fin) status_r <= cmd.fin_status;
      if (cmd.commit) begin
        hum_r    <= new_h;
        tmp_r    <= new_t;
        lvalid_r <= 1'b1;
        hsum_r   <= hsum_nxt;
        tsum_r   <= tsum_nxt;
        if (!full) cnt_r <= cnt_r + CNT_W'(1);
        pos_r <= (pos_r == HIST_AW'(HIST_DEPTH - 1)) ? '0 : pos_r + HIST_AW'(1);
      end
      if (cmd.load_avg && cmd.load_out) begin
        ahw_r <= ahw_new;
        ahh_r <= ahh_new;
        atw_r <= atw_new;
        ath_r <= ath_new;
      end
      if (cmd.load_out) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hum_mem[pos_r] <= new_h;
      tmp_mem[pos_r] <= new_t;
      dh_r   <= DIV_W'(hsum_nxt) * DIV_W'(100);
      dt_r   <= DIV_W'(tsum_nxt) * DIV_W'(100);
      rh_r   <= '0;
      rt_r   <= '0;
      dcnt_r <= DCNT_W'(DIV_W - 1);
    end else if (cmd.div_step) begin
      rh_r   <= geh ? rh_sh - dvs : rh_sh;
      rt_r   <= get ? rt_sh - dvs : rt_sh;
      dh_r   <= {dh_r[DIV_W-2:0], geh};
      dt_r   <= {dt_r[DIV_W-2:0], get};
      dcnt_r <= dcnt_r - DCNT_W'(1);
    end
    if (cmd.mul) begin
      ph_r <= PROD_W'(dh_r[HQ_W-1:0]) * PROD_W'(RECIP_100);
      pt_r <= PROD_W'(dt_r[HQ_W-1:0]) * PROD_W'(RECIP_100);
    end
    if (cmd.load_out) begin
      out_line_drive       <= cmd.drive;
      out_busy_res         <= cmd.busy;
      out_done_res         <= cmd.done;
      out_status           <= cmd.fin ? cmd.fin_status : status_r;
      out_humidity_last    <= hum_r;
      out_temperature_last <= tmp_r;
      out_last_valid       <= lvalid_r;
      out_average_valid    <= (cnt_r != '0);
      out_humidity_avg_whole         <= cmd.load_avg ? ahw_new : ahw_r;
      out_humidity_avg_hundredths    <= cmd.load_avg ? ahh_new : ahh_r;
      out_temperature_avg_whole      <= cmd.load_avg ? atw_new : atw_r;
      out_temperature_avg_hundredths <= cmd.load_avg ? ath_new : ath_r;
    end
  end

  assign out_valid = out_valid_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(HIST_DEPTH)) else $error("history count overflow");
  a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
    hsum_r <= SUM_W'(255) * SUM_W'(cnt_r) && tsum_r <= SUM_W'(255) * SUM_W'(cnt_r))
    else $error("running sum out of range");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r) else $error("stalled result dropped");

endmodule

// ===== sv/single_wire_humidity_sensor_reader.sv =====
// Top level of the single-wire humidity sensor reader.
//
//  channel | handshake                | payload
//  in_     | in_valid / in_stall      | in_start_req, in_line_level (one line tick)
//  out_    | out_valid / out_stall    | line drive, busy, done, status, last values, averages
//  cfg_    | cfg_valid / cfg_ready    | cfg_index (register 0..3), cfg_data
//
// A tick's result is registered at the end of the cycle that takes it, except for a tick
// that completes a good frame: its result waits for the bit-serial divider that forms both
// averages from the running sums, then for the reciprocal multiply into whole and hundredths.
// Input is stalled while the averages are formed or while a result waits on out_stall.
// Reset is synchronous; histories are never cleared, only counted.
module single_wire_humidity_sensor_reader import swhsr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_start_req,
  input  logic        in_line_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_line_drive,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic [1:0]  out_status,
  output logic [7:0]  out_humidity_last,
  output logic [7:0]  out_temperature_last,
  output logic        out_last_valid,
  output logic        out_average_valid,
  output logic [7:0]  out_humidity_avg_whole,
  output logic [6:0]  out_humidity_avg_hundredths,
  output logic [7:0]  out_temperature_avg_whole,
  output logic [6:0]  out_temperature_avg_hundredths,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  swhsr_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_start_req  (in_start_req),
    .in_line_level (in_line_level),
    .in_stall      (in_stall),
    .sts           (sts),
    .cmd           (cmd)
  );

  swhsr_dp u_dp (
    .clk                            (clk),
    .rst_n                          (rst_n),
    .cfg_valid                      (cfg_valid),
    .cfg_index                      (cfg_index),
    .cfg_data                       (cfg_data),
    .out_stall                      (out_stall),
    .cmd                            (cmd),
    .sts                            (sts),
    .out_valid                      (out_valid),
    .out_line_drive                 (out_line_drive),
    .out_busy_res                   (out_busy_res),
    .out_done_res                   (out_done_res),
    .out_status                     (out_status),
    .out_humidity_last              (out_humidity_last),
    .out_temperature_last           (out_temperature_last),
    .out_last_valid                 (out_last_valid),
    .out_average_valid              (out_average_valid),
    .out_humidity_avg_whole         (out_humidity_avg_whole),
    .out_humidity_avg_hundredths    (out_humidity_avg_hundredths),
    .out_temperature_avg_whole      (out_temperature_avg_whole),
    .out_temperature_avg_hundredths (out_temperature_avg_hundredths)
  );

endmodule
